// ----- sv/fsp_pkg.sv -----
// Package: shared constants and types for the sync/length/XOR frame parser.
`timescale 1ns / 1ps

package fsp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;
    localparam int         STORE_DEPTH = 16;
    localparam int         IDX_W       = 4;   // log2 of STORE_DEPTH
    localparam int         LEN_W       = 5;   // holds 0..STORE_DEPTH

    typedef enum logic [2:0] {
        PH_SYNC0,
        PH_SYNC1,
        PH_TYPE,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } t_phase;

    // One unit of work for the back end: a raw byte or a checked frame.
    typedef struct packed {
        logic             frame;
        logic [7:0]       ftype;
        logic [LEN_W-1:0] flen;
        logic [7:0]       raw;
        logic             bank;
    } t_job;

    // Payload write from the front end into the back end's store.
    typedef struct packed {
        logic             we;
        logic             bank;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } t_wr;

    // Payload bank handed back once its last byte has been read.
    typedef struct packed {
        logic rel;
        logic bank;
    } t_rel;

endpackage

// ----- sv/fsp_front.sv -----
// Front end: byte-level frame parser that classifies words into jobs.
`timescale 1ns / 1ps

module fsp_front #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [7:0]    i_in_byte,
    input  logic          i_q_full,
    output logic          o_job_push,
    output fsp_pkg::t_job o_job,
    output fsp_pkg::t_wr  o_wr,
    input  fsp_pkg::t_rel i_rel
);
    import fsp_pkg::*;

    localparam int LIMIT = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_type, n_type;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_fill, n_fill;
    logic [7:0]       r_check, n_check;
    logic             r_wr_bank, n_wr_bank;
    logic [1:0]       r_busy, n_busy;
    logic             accept;
    logic             len_bad;
    logic [LEN_W-1:0] fill_inc;
    logic             frame_push;

    // Stall on a full job queue, or when the bank being filled is still draining.
    assign o_full   = i_q_full || (r_phase == PH_DATA && r_busy[r_wr_bank]);
    assign accept   = i_push && !o_full;
    assign len_bad  = 9'(i_in_byte) > 9'(LIMIT);
    assign fill_inc = r_fill + LEN_W'(1);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_SYNC0: n_phase = (i_in_byte == SYNC_FIRST) ? PH_SYNC1 : PH_SYNC0;
                PH_SYNC1: begin
                    if (i_in_byte == SYNC_SECOND)     n_phase = PH_TYPE;
                    else if (i_in_byte != SYNC_FIRST) n_phase = PH_SYNC0;
                end
                PH_TYPE:  n_phase = PH_LEN;
                PH_LEN: begin
                    if (len_bad)                n_phase = PH_SYNC0;
                    else if (i_in_byte == 8'd0) n_phase = PH_CHECK;
                    else                        n_phase = PH_DATA;
                end
                PH_DATA:  n_phase = (fill_inc >= r_len) ? PH_CHECK : PH_DATA;
                PH_CHECK: n_phase = PH_SYNC0;
                default:  n_phase = PH_SYNC0;
            endcase
        end
    end

    // Datapath and outputs
    always_comb begin
        n_type     = r_type;
        n_len      = r_len;
        n_fill     = r_fill;
        n_check    = r_check;
        n_wr_bank  = r_wr_bank;
        o_job_push = 1'b0;
        frame_push = 1'b0;
        o_job      = '{frame: 1'b0, ftype: 8'd0, flen: '0, raw: i_in_byte, bank: r_wr_bank};
        o_wr       = '{we: 1'b0, bank: r_wr_bank, addr: r_fill[IDX_W-1:0], data: i_in_byte};
        if (accept) begin
            case (r_phase)
                PH_SYNC0: o_job_push = (i_in_byte != SYNC_FIRST);
                PH_SYNC1: ;
                PH_TYPE:  n_type = i_in_byte;
                PH_LEN: begin
                    if (!len_bad) begin
                        n_len   = i_in_byte[LEN_W-1:0];
                        n_fill  = '0;
                        n_check = r_type ^ i_in_byte;
                    end
                end
                PH_DATA: begin
                    o_wr.we = 1'b1;
                    n_check = r_check ^ i_in_byte;
                    n_fill  = fill_inc;
                end
                PH_CHECK: begin
                    if (i_in_byte == r_check) begin
                        o_job_push = 1'b1;
                        frame_push = 1'b1;
                        o_job      = '{frame: 1'b1, ftype: r_type, flen: r_len,
                                       raw: 8'd0, bank: r_wr_bank};
                        if (r_len != '0) n_wr_bank = !r_wr_bank;
                    end
                end
                default: ;
            endcase
            if (n_phase == PH_SYNC0) begin
                n_type  = 8'd0;
                n_len   = '0;
                n_fill  = '0;
                n_check = 8'd0;
            end
        end
    end

    // Bank ownership: set when a frame with payload is queued, cleared on release.
    always_comb begin
        n_busy = r_busy;
        if (i_rel.rel) n_busy[i_rel.bank] = 1'b0;
        if (frame_push && r_len != '0) n_busy[r_wr_bank] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC0;
            r_type    <= 8'd0;
            r_len     <= '0;
            r_fill    <= '0;
            r_check   <= 8'd0;
            r_wr_bank <= 1'b0;
            r_busy    <= 2'b00;
        end else begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_len     <= n_len;
            r_fill    <= n_fill;
            r_check   <= n_check;
            r_wr_bank <= n_wr_bank;
            r_busy    <= n_busy;
        end
    end

    a_no_write_busy_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.we |-> !r_busy[o_wr.bank])
        else $error("payload write into a bank still being drained");

endmodule

// ----- sv/fsp_jobq.sv -----
// Job queue: short FIFO between the parser front end and the emitter back end.
`timescale 1ns / 1ps

module fsp_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fsp_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output fsp_pkg::t_job o_job,
    output logic          o_valid
);
    import fsp_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    t_job             r_slot [DEPTH];
    logic [PTR_W-1:0] r_head, r_tail;
    logic [PTR_W:0]   r_count;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_tail] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_tail <= r_tail + PTR_W'(1);
            if (i_pop)  r_head <= r_head + PTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue overflow");

endmodule

// ----- sv/fsp_back.sv -----
// Back end: payload store and emitter that turns jobs into result words.
`timescale 1ns / 1ps

module fsp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fsp_pkg::t_wr                i_wr,
    input  logic                        i_q_valid,
    input  fsp_pkg::t_job               i_q_job,
    output logic                        o_q_pop,
    output fsp_pkg::t_rel               o_rel,
    output logic                        empty,
    input  logic                        pop,
    output logic                        o_kind,
    output logic [7:0]                  o_frame_type,
    output logic [fsp_pkg::LEN_W-1:0]   o_frame_length,
    output logic [fsp_pkg::IDX_W-1:0]   o_element_index,
    output logic [7:0]                  o_element_byte,
    output logic                        o_has_data,
    output logic                        o_last
);
    import fsp_pkg::*;

    typedef struct packed {
        logic             kind;
        logic [7:0]       ftype;
        logic [LEN_W-1:0] flen;
        logic [IDX_W-1:0] idx;
        logic [7:0]       raw;
        logic             has;
        logic             last;
        logic             use_mem;
    } t_meta;

    logic [7:0]       r_mem [2*STORE_DEPTH];
    logic             r_active;
    t_job             r_job;
    logic [IDX_W-1:0] r_idx;
    logic             r_s1_valid;
    t_meta            r_s1;
    logic [7:0]       r_rdata;
    logic             r_s2_valid;
    t_meta            r_s2;
    logic [7:0]       r_s2_byte;

    t_meta            issue_meta;
    logic             has_payload;
    logic             issue_last;
    logic             s2_load;
    logic             s1_load;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) r_mem[{i_wr.bank, i_wr.addr}] <= i_wr.data;
    end

    assign has_payload = r_job.frame && (r_job.flen != '0);
    assign issue_last  = !has_payload || ({1'b0, r_idx} + LEN_W'(1) == r_job.flen);

    always_comb begin
        if (!r_job.frame) begin
            issue_meta = '{kind: 1'b0, ftype: 8'd0, flen: '0, idx: '0,
                           raw: r_job.raw, has: 1'b1, last: 1'b1, use_mem: 1'b0};
        end else if (!has_payload) begin
            issue_meta = '{kind: 1'b1, ftype: r_job.ftype, flen: '0, idx: '0,
                           raw: 8'd0, has: 1'b0, last: 1'b1, use_mem: 1'b0};
        end else begin
            issue_meta = '{kind: 1'b1, ftype: r_job.ftype, flen: r_job.flen, idx: r_idx,
                           raw: 8'd0, has: 1'b1, last: issue_last, use_mem: 1'b1};
        end
    end

    assign s2_load = r_s1_valid && (!r_s2_valid || pop);
    assign s1_load = r_active && (!r_s1_valid || s2_load);
    assign o_q_pop = i_q_valid && (!r_active || (s1_load && issue_last));
    assign o_rel   = '{rel: s1_load && issue_last && has_payload, bank: r_job.bank};

    // Job sequencer: one element per cycle into the read stage, unless the stages ahead are held up by pop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (o_q_pop) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (s1_load) begin
                if (issue_last) begin
                    r_active <= 1'b0;
                    r_idx    <= '0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_job <= i_q_job;
    end

    // Read stage (registered store read) and output register.
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1    <= issue_meta;
            r_rdata <= r_mem[{r_job.bank, r_idx}];
        end
        if (s2_load) begin
            r_s2      <= r_s1;
            r_s2_byte <= r_s1.use_mem ? r_rdata : r_s1.raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_load)     r_s1_valid <= 1'b1;
            else if (s2_load) r_s1_valid <= 1'b0;
            if (s2_load)     r_s2_valid <= 1'b1;
            else if (pop)    r_s2_valid <= 1'b0;
        end
    end

    assign empty           = !r_s2_valid;
    assign o_kind          = r_s2.kind;
    assign o_frame_type    = r_s2.ftype;
    assign o_frame_length  = r_s2.flen;
    assign o_element_index = r_s2.idx;
    assign o_element_byte  = r_s2_byte;
    assign o_has_data      = r_s2.has;
    assign o_last          = r_s2.last;

    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && has_payload) |-> ({1'b0, r_idx} < r_job.flen))
        else $error("element index ran past frame length");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_load && issue_last && !o_q_pop) |=> !r_active)
        else $error("sequencer stayed active after last element");

endmodule

// ----- sv/sync_length_xor_frame_parser.sv -----
// Top level: two-byte sync, type/length/XOR-checksum frame parser.
`timescale 1ns / 1ps

// Takes one received byte per word and hunts for the sync pair A5 5A, then a
// type byte, a length byte (up to the smaller of MAX_PAYLOAD and 16), the
// payload and an XOR checksum over type, length and payload. A good frame
// comes out as one result word per payload byte (kind=1, last on the final
// one), or one data-less word for an empty frame; a bad frame is dropped.
// Bytes seen while hunting for the first sync byte that are not A5 come out
// as raw words (kind=0). The input takes one byte per cycle while full is
// low. The parser front end queues jobs into a 4-entry queue; the back end
// emits one result per cycle while pop is held, from a two-bank payload
// store, so a frame drains while the next one is being received. full rises
// when the job queue is full, or when a third frame's payload would land in
// a bank whose frame is still being emitted. No clearing pass is needed
// after reset.
module sync_length_xor_frame_parser #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                i_in_byte,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_kind,
    output logic [7:0]                o_frame_type,
    output logic [fsp_pkg::LEN_W-1:0] o_frame_length,
    output logic [fsp_pkg::IDX_W-1:0] o_element_index,
    output logic [7:0]                o_element_byte,
    output logic                      o_has_data,
    output logic                      o_last
);
    import fsp_pkg::*;

    logic q_full;
    logic job_push;
    t_job job_in;
    t_job job_out;
    logic q_valid;
    logic q_pop;
    t_wr  wr;
    t_rel rel;

    // Front end: parser state machine, checksum and payload writes.
    fsp_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (job_in),
        .o_wr       (wr),
        .i_rel      (rel)
    );

    // Decoupling queue of raw-byte and frame jobs.
    fsp_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (job_out),
        .o_valid (q_valid)
    );

    // Back end: payload store, element sequencer and output register.
    fsp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (wr),
        .i_q_valid       (q_valid),
        .i_q_job         (job_out),
        .o_q_pop         (q_pop),
        .o_rel           (rel),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_frame_type    (o_frame_type),
        .o_frame_length  (o_frame_length),
        .o_element_index (o_element_index),
        .o_element_byte  (o_element_byte),
        .o_has_data      (o_has_data),
        .o_last          (o_last)
    );

endmodule

// ----- bench/sync_length_xor_frame_parser_check.sv -----
// Checker: predicts the frame parser's result words and compares them as they are popped.
`timescale 1ns / 1ps

module sync_length_xor_frame_parser_check #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic                      i_full,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_empty,
    input  logic                      i_pop,
    input  logic                      i_kind,
    input  logic [7:0]                i_frame_type,
    input  logic [fsp_pkg::LEN_W-1:0] i_frame_length,
    input  logic [fsp_pkg::IDX_W-1:0] i_element_index,
    input  logic [7:0]                i_element_byte,
    input  logic                      i_has_data,
    input  logic                      i_last,
    output int                        o_fail_count,
    output int                        o_pending
);
    import fsp_pkg::*;

    localparam int LEN_LIMIT = (MAX_PAYLOAD < STORE_DEPTH) ? MAX_PAYLOAD : STORE_DEPTH;

    typedef struct packed {
        logic             kind;
        logic [7:0]       ftype;
        logic [LEN_W-1:0] flen;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic             has_data;
        logic             is_last;
    } t_word;

    t_phase           phase;
    logic [7:0]       held_type;
    logic [LEN_W-1:0] held_len;
    logic [LEN_W-1:0] fill;
    logic [7:0]       running_xor;
    logic [7:0]       payload [STORE_DEPTH];
    t_word            frame_words_due [$];

    task automatic restart_hunt();
        phase       = PH_SYNC0;
        held_type   = 8'h00;
        held_len    = '0;
        fill        = '0;
        running_xor = 8'h00;
    endtask

    // One received byte through the parser; queues the words it releases.
    task automatic parse_byte(input logic [7:0] b);
        int k;
        case (phase)
            PH_SYNC0: begin
                if (b == SYNC_FIRST) begin
                    phase = PH_SYNC1;
                end else begin
                    frame_words_due.push_back('{kind: 1'b0, ftype: 8'h00, flen: '0, idx: '0,
                                                data: b, has_data: 1'b1, is_last: 1'b1});
                end
            end
            PH_SYNC1: begin
                if (b == SYNC_SECOND) begin
                    phase = PH_TYPE;
                end else if (b != SYNC_FIRST) begin
                    restart_hunt();
                end
            end
            PH_TYPE: begin
                held_type = b;
                phase     = PH_LEN;
            end
            PH_LEN: begin
                if (int'(b) > LEN_LIMIT) begin
                    restart_hunt();
                end else begin
                    held_len    = LEN_W'(b);
                    fill        = '0;
                    running_xor = held_type ^ b;
                    phase       = (b == 8'h00) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA: begin
                payload[fill[IDX_W-1:0]] = b;
                running_xor = running_xor ^ b;
                fill        = fill + LEN_W'(1);
                if (fill >= held_len) phase = PH_CHECK;
            end
            PH_CHECK: begin
                if (b == running_xor) begin
                    if (held_len == '0) begin
                        frame_words_due.push_back('{kind: 1'b1, ftype: held_type, flen: '0,
                                                    idx: '0, data: 8'h00, has_data: 1'b0,
                                                    is_last: 1'b1});
                    end else begin
                        for (k = 0; k < int'(held_len); k++) begin
                            frame_words_due.push_back('{kind: 1'b1, ftype: held_type,
                                                        flen: held_len, idx: IDX_W'(k),
                                                        data: payload[k], has_data: 1'b1,
                                                        is_last: (k + 1 == int'(held_len))});
                        end
                    end
                end
                restart_hunt();
            end
            default: restart_hunt();
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    task automatic check_word();
        t_word want;
        if (frame_words_due.size() == 0) begin
            $error("unexpected result word: kind %0b type %0h byte %0h",
                   i_kind, i_frame_type, i_element_byte);
            o_fail_count++;
        end else begin
            want = frame_words_due.pop_front();
            cmp_field("kind", 32'(want.kind), 32'(i_kind));
            cmp_field("frame_type", 32'(want.ftype), 32'(i_frame_type));
            cmp_field("frame_length", 32'(want.flen), 32'(i_frame_length));
            cmp_field("element_index", 32'(want.idx), 32'(i_element_index));
            cmp_field("element_byte", 32'(want.data), 32'(i_element_byte));
            cmp_field("has_data", 32'(want.has_data), 32'(i_has_data));
            cmp_field("last", 32'(want.is_last), 32'(i_last));
        end
    endtask

    // Input side first: no word can leave in the cycle its byte goes in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_hunt();
            frame_words_due.delete();
        end else begin
            if (i_push && !i_full) parse_byte(i_in_byte);
            if (i_pop && !i_empty) check_word();
        end
        o_pending = frame_words_due.size();
    end

endmodule

// ----- bench/sync_length_xor_frame_parser_test.sv -----
// Testbench top: byte stimulus, result-side stalls and the verdict for the frame parser.
`timescale 1ns / 1ps

module sync_length_xor_frame_parser_test;
    import fsp_pkg::*;

    localparam int MAX_PAYLOAD   = 16;
    localparam int HALF_PERIOD   = 6;      // 12 ns clock
    localparam int RANDOM_BYTES  = 280;
    localparam int DRAIN_CYCLES  = 16;     // margin on top of the result latency
    localparam int LIMIT_CYCLES  = 200000;

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                push      = 1'b0;
    logic                pop       = 1'b0;
    logic [7:0]          i_in_byte = 8'h00;
    logic                full;
    logic                empty;
    logic                o_kind;
    logic [7:0]          o_frame_type;
    logic [LEN_W-1:0]    o_frame_length;
    logic [IDX_W-1:0]    o_element_index;
    logic [7:0]          o_element_byte;
    logic                o_has_data;
    logic                o_last;

    int fail_count;
    int words_pending;
    int bytes_sent = 0;
    bit quiet      = 1'b0;    // no idling on either side while set

    sync_length_xor_frame_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length),
        .o_element_index(o_element_index),
        .o_element_byte (o_element_byte),
        .o_has_data     (o_has_data),
        .o_last         (o_last)
    );

    sync_length_xor_frame_parser_check #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_in_byte      (i_in_byte),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (o_kind),
        .i_frame_type   (o_frame_type),
        .i_frame_length (o_frame_length),
        .i_element_index(o_element_index),
        .i_element_byte (o_element_byte),
        .i_has_data     (o_has_data),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (words_pending)
    );

    always begin
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
        #HALF_PERIOD;
    end

    // Result side: stall about 30% of cycles unless the quiet window is on.
    always @(negedge i_clk) begin
        pop <= quiet || ($urandom_range(0, 99) >= 30);
    end

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    // push gets one assignment per falling edge, so back-to-back words keep it high.
    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 30) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Sync pair, type, length, then 'cut' payload bytes. The checksum goes out only
    // when the whole payload was sent; bad_sum flips at least one bit of it.
    task automatic send_frame(input logic [7:0] ftype, input int len, input int cut,
                              input bit bad_sum);
        logic [7:0] xsum;
        logic [7:0] b;
        int k;
        xsum = ftype ^ 8'(len);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(ftype);
        send_byte(8'(len));
        for (k = 0; k < cut; k++) begin
            b = 8'($urandom_range(0, 255));
            xsum ^= b;
            send_byte(b);
        end
        if (cut == len) send_byte(bad_sum ? xsum ^ 8'($urandom_range(1, 255)) : xsum);
    endtask

    initial begin
        int start_count;
        int pick;
        int len;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: raw bytes at the extremes, including a lone second sync byte.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND);
        // Repeated first sync byte, then an empty frame.
        send_byte(SYNC_FIRST);
        send_frame(8'h3C, 0, 0, 1'b0);
        // First sync followed by a foreign byte: back to the hunt, nothing out.
        send_byte(SYNC_FIRST);
        send_byte(8'h12);
        // Length one above the limit.
        send_frame(8'h01, MAX_PAYLOAD + 1, 0, 1'b0);
        // Bad checksum drops the frame.
        send_frame(8'h07, 1, 1, 1'b1);
        // Good two-byte frame.
        send_frame(8'hFF, 2, 2, 1'b0);

        // Random: mostly well-formed frames, the rest noise and broken frames.
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            // One long window with no idling on either side.
            quiet = (bytes_sent - start_count >= 120) && (bytes_sent - start_count < 200);
            pick  = $urandom_range(0, 99);
            if (pick < 60) begin
                case ($urandom_range(0, 9))
                    0:       len = MAX_PAYLOAD;
                    1:       len = 0;
                    2:       len = $urandom_range(6, MAX_PAYLOAD - 1);
                    default: len = $urandom_range(1, 5);
                endcase
                if ($urandom_range(0, 4) == 0) send_byte(SYNC_FIRST);
                send_frame(8'($urandom_range(0, 255)), len, len, $urandom_range(0, 99) < 15);
            end else if (pick < 75) begin
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 85) begin
                // Broken sync: first byte, maybe repeated, then anything.
                repeat ($urandom_range(1, 3)) send_byte(SYNC_FIRST);
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 95) begin
                send_frame(8'($urandom_range(0, 255)), $urandom_range(MAX_PAYLOAD + 1, 255),
                           0, 1'b0);
            end else begin
                // Truncated frame: the following bytes land inside it.
                len = $urandom_range(1, MAX_PAYLOAD);
                send_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, len - 1), 1'b0);
            end
        end
        quiet = 1'b0;
        push <= 1'b0;

        // Drain, then give the block time to show any stray word.
        while (words_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin
        #(2 * HALF_PERIOD * LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sync_length_xor_frame_parser.f -----
sv/fsp_pkg.sv
sv/fsp_front.sv
sv/fsp_jobq.sv
sv/fsp_back.sv
sv/sync_length_xor_frame_parser.sv
bench/sync_length_xor_frame_parser_check.sv
bench/sync_length_xor_frame_parser_test.sv
